// File: rtl/keycode_line_editor_assert.svh
// Assertion macros for the asserting file of the line editor, keycode_line_editor.sv.
`ifndef KEYCODE_LINE_EDITOR_ASSERT_SVH
`define KEYCODE_LINE_EDITOR_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset.
`define KLE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define KLE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/kle_pkg.sv
package kle_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int COL_W      = 5;
    localparam int CNT_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int CODE_W     = 8;

    localparam logic [1:0] OP_NOP       = 2'd0;
    localparam logic [1:0] OP_APPEND    = 2'd1;
    localparam logic [1:0] OP_BACKSPACE = 2'd2;
    localparam logic [1:0] OP_CLEAR     = 2'd3;

    localparam logic [CODE_W-1:0] KEY_A_FIRST    = 8'h04;
    localparam logic [CODE_W-1:0] KEY_A_LAST     = 8'h1D;
    localparam logic [CODE_W-1:0] KEY_D_FIRST    = 8'h1E;
    localparam logic [CODE_W-1:0] KEY_D_LAST     = 8'h27;
    localparam logic [CODE_W-1:0] KEY_RETURN     = 8'h28;
    localparam logic [CODE_W-1:0] KEY_ERASE      = 8'h2A;
    localparam logic [CODE_W-1:0] KEY_P_FIRST    = 8'h2C;
    localparam logic [CODE_W-1:0] KEY_P_LAST     = 8'h38;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_CURSOR  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] ch;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qout;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [CHAR_W-1:0] char_code;
        logic              cursor_overlay;
        logic [CNT_W-1:0]  line_count;
        logic              last;
    } t_res;

    function automatic logic [CHAR_W-1:0] punct_char(input logic [3:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            4'd0:    c = 8'h20;
            4'd1:    c = 8'h2D;
            4'd2:    c = 8'h3D;
            4'd3:    c = 8'h5B;
            4'd4:    c = 8'h5D;
            4'd5:    c = 8'h5C;
            4'd6:    c = 8'h23;
            4'd7:    c = 8'h3B;
            4'd8:    c = 8'h27;
            4'd9:    c = 8'h60;
            4'd10:   c = 8'h2C;
            4'd11:   c = 8'h2E;
            4'd12:   c = 8'h2F;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/kle_front.sv
module kle_front
    import kle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic              i_cmd,
    input  logic [CODE_W-1:0] i_key_code,
    output logic              o_wr,
    output t_op               o_op
);

    logic r_blank;
    logic n_blank;
    logic accept;
    logic mapped;
    logic [CHAR_W-1:0] ascii;
    logic [CODE_W-1:0] ofs;

    assign accept = i_push && !i_full;

    always_comb begin
        ofs    = '0;
        mapped = 1'b1;
        ascii  = CH_SPACE;
        n_blank = r_blank;
        priority if (r_blank && i_key_code != KEY_RETURN) begin
            ascii = CH_STAR;
        end else if (i_key_code >= KEY_A_FIRST && i_key_code <= KEY_A_LAST) begin
            ofs   = i_key_code - KEY_A_FIRST;
            ascii = CH_UPPER_A + ofs;
        end else if (i_key_code == KEY_D_LAST) begin
            ascii = CH_ZERO;
        end else if (i_key_code >= KEY_D_FIRST && i_key_code < KEY_D_LAST) begin
            ofs   = i_key_code - KEY_D_FIRST;
            ascii = CH_ONE + ofs;
        end else if (i_key_code >= KEY_P_FIRST && i_key_code <= KEY_P_LAST) begin
            ofs   = i_key_code - KEY_P_FIRST;
            ascii = punct_char(ofs[3:0]);
        end else begin
            mapped = 1'b0;
        end

        o_op.ch = ascii;
        priority if (mapped) begin
            o_op.kind = OP_APPEND;
        end else if (i_key_code == KEY_ERASE) begin
            o_op.kind = OP_BACKSPACE;
        end else if (i_key_code == KEY_RETURN) begin
            o_op.kind = OP_CLEAR;
        end else begin
            o_op.kind = OP_NOP;
        end

        if (accept) begin
            if (i_cmd) begin
                n_blank = !r_blank;
            end else if (i_key_code == KEY_RETURN) begin
                n_blank = 1'b0;
            end
        end
    end

    assign o_wr = accept && !i_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank <= 1'b0;
        end else begin
            r_blank <= n_blank;
        end
    end

endmodule

// File: rtl/kle_queue.sv
module kle_queue
    import kle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_op   i_op,
    output logic  o_full,
    input  logic  i_rd,
    output t_qout o_q
);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    t_op r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;
    logic do_wr;
    logic do_rd;

    function automatic logic [Q_AW-1:0] q_next(input logic [Q_AW-1:0] p);
        return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full   = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_q.valid = (r_cnt != '0);
    assign o_q.op    = r_mem[r_rp];
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && o_q.valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= q_next(r_wp);
            end
            if (do_rd) begin
                r_rp <= q_next(r_rp);
            end
            r_cnt <= r_cnt + Q_CW'(do_wr) - Q_CW'(do_rd);
        end
    end

endmodule

// File: rtl/kle_back.sv
module kle_back
    import kle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_qout i_q,
    output logic  o_rd,
    input  logic  i_pop,
    output logic  o_empty,
    output t_res  o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    localparam int OF_DEPTH = 2;
    localparam int OF_AW    = $clog2(OF_DEPTH);
    localparam int OF_CW    = $clog2(OF_DEPTH + 1);

    logic [CHAR_W-1:0] r_line [LINE_DEPTH];

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    t_op              r_op;
    logic [IDX_W-1:0] r_old;
    logic [IDX_W-1:0] n_old;
    logic [CNT_W-1:0] r_held;
    logic [CNT_W-1:0] n_held;
    logic [IDX_W-1:0] r_col;

    logic              r_infl;
    t_res              r_meta;
    logic              r_use_mem;
    logic [CHAR_W-1:0] r_rdata;

    t_res             r_of [OF_DEPTH];
    logic [OF_AW-1:0] r_of_wp;
    logic [OF_AW-1:0] r_of_rp;
    logic [OF_CW-1:0] r_of_cnt;

    logic             is_full;
    logic [IDX_W-1:0] old_a;
    logic [CNT_W-1:0] held_a;
    logic [IDX_W-1:0] waddr;
    logic             do_write;
    logic             pop_fire;
    logic [OF_CW:0]   occ;
    logic             issue;
    logic [IDX_W-1:0] raddr;
    t_res             meta;
    logic             use_mem;
    t_res             push_res;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (s >= (CNT_W + 1)'(LINE_DEPTH)) begin
            s = s - (CNT_W + 1)'(LINE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [OF_AW-1:0] of_next(input logic [OF_AW-1:0] p);
        return (p == OF_AW'(OF_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_rd = (r_state == ST_IDLE);

    always_comb begin
        is_full  = (r_held == CNT_W'(LINE_DEPTH));
        old_a    = is_full ? ring_add(r_old, CNT_W'(1)) : r_old;
        held_a   = is_full ? CNT_W'(LINE_DEPTH - 1) : r_held;
        waddr    = ring_add(old_a, held_a);
        do_write = (r_state == ST_EXEC) && (r_op.kind == OP_APPEND);
        n_old    = r_old;
        n_held   = r_held;
        if (r_state == ST_EXEC) begin
            unique case (r_op.kind)
                OP_APPEND: begin
                    n_old  = old_a;
                    n_held = held_a + 1'b1;
                end
                OP_BACKSPACE: begin
                    if (r_held != '0) begin
                        n_held = r_held - 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_old  = '0;
                    n_held = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign pop_fire = i_pop && !o_empty;
    assign occ      = (OF_CW + 1)'(r_of_cnt) + (OF_CW + 1)'(r_infl) - (OF_CW + 1)'(pop_fire);
    assign issue    = (r_state == ST_RUN) && (occ < (OF_CW + 1)'(OF_DEPTH));
    assign raddr    = ring_add(r_old, CNT_W'(r_col));

    always_comb begin
        meta.column         = COL_W'(r_col);
        meta.line_count     = r_held;
        meta.last           = (r_col == IDX_W'(LINE_DEPTH - 1));
        meta.cursor_overlay = 1'b0;
        use_mem             = 1'b0;
        priority if (CNT_W'(r_col) < r_held) begin
            use_mem             = 1'b1;
            meta.char_code      = CH_SPACE;
            meta.cursor_overlay = is_full && meta.last;
        end else if (CNT_W'(r_col) == r_held) begin
            meta.char_code = CH_CURSOR;
        end else begin
            meta.char_code = CH_SPACE;
        end
    end

    always_comb begin
        push_res = r_meta;
        if (r_use_mem) begin
            push_res.char_code = r_rdata;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (issue && meta.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_line[waddr] <= r_op.ch;
        end
        if (issue) begin
            r_rdata <= r_line[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q.valid) begin
            r_op <= i_q.op;
        end
        if (issue) begin
            r_meta    <= meta;
            r_use_mem <= use_mem;
        end
        if (r_infl) begin
            r_of[r_of_wp] <= push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_old    <= '0;
            r_held   <= '0;
            r_col    <= '0;
            r_infl   <= 1'b0;
            r_of_wp  <= '0;
            r_of_rp  <= '0;
            r_of_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_old   <= n_old;
            r_held  <= n_held;
            r_infl  <= issue;
            if (r_state == ST_EXEC) begin
                r_col <= '0;
            end else if (issue) begin
                r_col <= r_col + 1'b1;
            end
            if (r_infl) begin
                r_of_wp <= of_next(r_of_wp);
            end
            if (pop_fire) begin
                r_of_rp <= of_next(r_of_rp);
            end
            r_of_cnt <= r_of_cnt + OF_CW'(r_infl) - OF_CW'(pop_fire);
        end
    end

    assign o_empty = (r_of_cnt == '0);
    assign o_res   = r_of[r_of_rp];

endmodule

// File: rtl/keycode_line_editor.sv
// Keycode line editor: a one-line text buffer driven by keyboard usage codes.
// Input channel (push/full): a beat carries i_cmd and i_key_code. i_cmd = 1
// toggles password mode and makes no results; i_cmd = 0 is a key event.
// Result channel (empty/pop): every key event redraws the line as 32 beats,
// column 0 to 31, each with the shown character, the cursor overlay flag,
// the character count and o_last on column 31.
// The executor handles one key at a time: it takes the operation, updates
// the line, then issues one column per cycle from the single read port of
// the line memory while the result buffer has room. Up to two keys wait in
// the queue in front, so full rises only when keys arrive faster than the
// executor takes them. A toggle is handled in the front end alone.
// Reset clears the count, the ring position and password mode; the line
// memory is not cleared, since only written entries are ever shown.
// When pop is held low the two-entry result buffer fills, the executor
// stops issuing columns, and once the queue fills, full is raised.
module keycode_line_editor
    import kle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic              i_cmd,
    input  logic [CODE_W-1:0] i_key_code,
    output logic              empty,
    input  logic              pop,
    output logic [COL_W-1:0]  o_column,
    output logic [CHAR_W-1:0] o_char_code,
    output logic              o_cursor_overlay,
    output logic [CNT_W-1:0]  o_line_count,
    output logic              o_last
);

`include "keycode_line_editor_assert.svh"

    logic  wr;
    t_op   op;
    t_qout q;
    logic  rd;
    t_res  res;

    kle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_cmd      (i_cmd),
        .i_key_code (i_key_code),
        .o_wr       (wr),
        .o_op       (op)
    );

    kle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_op    (op),
        .o_full  (full),
        .i_rd    (rd),
        .o_q     (q)
    );

    kle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q),
        .o_rd    (rd),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (res)
    );

    assign o_column         = res.column;
    assign o_char_code      = res.char_code;
    assign o_cursor_overlay = res.cursor_overlay;
    assign o_line_count     = res.line_count;
    assign o_last           = res.last;

    `KLE_ASSERT_IMPLIES(a_overlay_full, !empty && o_cursor_overlay,
        o_last && o_line_count == CNT_W'(LINE_DEPTH), "overlay off a full line's end")
    `KLE_ASSERT_IMPLIES(a_last_col, !empty && o_last,
        o_column == COL_W'(LINE_DEPTH - 1), "last flag off the final column")
    `KLE_ASSERT_IMPLIES(a_cursor_char, !empty && CNT_W'(o_column) == o_line_count,
        o_char_code == CH_CURSOR, "cursor column without underscore")
    `KLE_ASSERT_IMPLIES(a_blank_char, !empty && CNT_W'(o_column) > o_line_count,
        o_char_code == CH_SPACE, "column past cursor not blank")
    `KLE_ASSERT_ALWAYS(a_count_range, empty || o_line_count <= CNT_W'(LINE_DEPTH),
        "line count beyond depth")

endmodule
